// File: design/ism_pkg.sv
// Shared constants for the interval set merge and pop unit.
// Holds the result status codes and the item kind codes; depends on nothing.
package ism_pkg;
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_ORDER = 2'd2;
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_POP = 1'b1;
endpackage

// File: design/ism_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stands alone; used by the interval set unit to hold interval bounds.
module ism_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/interval_set_merge_and_pop_unit.sv
// Top level of the interval set merge and pop unit: control sequencer and result register.
// Depends on ism_pkg and ism_ram, which holds the sorted intervals as {high, low}.
//
// Channel   Direction  Contents
// s_*       in         tuser: kind; tdata: range_start, range_end, query_value
// m_*       out        tdata: found, status, set_empty, entry_count
//
// An item scans table entries in order and then moves entries to open or close a gap.
// Scanned and moved entries together number at most one more than those held.
// The single RAM port pair paces the work: each moved entry is read, then written back.
// Reset clears the entry count and the control state; RAM contents are never cleared.
// A new transaction is taken while a result waits in the output register.
module interval_set_merge_and_pop_unit
	import ism_pkg::*;
#(
	parameter int MAX_INTERVALS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// Lowest bit up: range_start, range_end, query_value, zero fill.
	input  logic [((3*VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// kind.
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// Lowest bit up: found, status, set_empty, entry_count, zero fill.
	output logic [((4+$clog2(MAX_INTERVALS+1)+7)/8)*8-1:0] m_tdata
);
	localparam int AW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int VB = VALUE_BITS;
	localparam int OW = ((4 + CW + 7) / 8) * 8;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN_RD = 3'd1;
	localparam logic [2:0] ST_SCAN_CHK = 3'd2;
	localparam logic [2:0] ST_RESOLVE = 3'd3;
	localparam logic [2:0] ST_UP_RD = 3'd4;
	localparam logic [2:0] ST_UP_WR = 3'd5;
	localparam logic [2:0] ST_DN_RD = 3'd6;
	localparam logic [2:0] ST_DN_WR = 3'd7;

	localparam logic [1:0] PH_FIND_I = 2'd0;
	localparam logic [1:0] PH_FIND_J = 2'd1;
	localparam logic [1:0] PH_POP = 2'd2;

	logic [2:0]    state_q;
	logic          done_q;
	logic [1:0]    phase_q;
	logic [VB-1:0] start_q, end_q, value_q, mlo_q, mhi_q;
	logic [CW-1:0] held_q, idx_q, i_q, src_q, delta_q;
	logic          found_q;
	logic [1:0]    status_q;
	logic          mvalid_q;
	logic [OW-1:0] mdata_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [2*VB-1:0] wdata, rdata;
	logic [VB-1:0] rd_lo, rd_hi;
	logic          finish;

	ism_ram #(.WIDTH(2 * VB), .DEPTH(MAX_INTERVALS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign rd_lo = rdata[VB-1:0];
	assign rd_hi = rdata[2*VB-1:VB];
	assign s_tready = (state_q == ST_IDLE) && !done_q;
	assign finish = done_q && (!mvalid_q || m_tready);
	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = {end_q, start_q};
		raddr = '0;
		case (state_q)
			ST_SCAN_RD: raddr = idx_q[AW-1:0];
			ST_SCAN_CHK: begin
				if (phase_q == PH_POP && rd_hi >= value_q && value_q >= rd_lo
						&& value_q != rd_hi) begin
					we = 1'b1;
					waddr = idx_q[AW-1:0];
					wdata = {rd_hi, value_q + VB'(1)};
				end
			end
			ST_RESOLVE: begin
				if (phase_q == PH_FIND_J) begin
					we = 1'b1;
					waddr = i_q[AW-1:0];
					wdata = {mhi_q, mlo_q};
				end
			end
			ST_UP_RD: begin
				raddr = AW'(src_q - CW'(1));
				if (src_q == i_q) begin
					we = 1'b1;
					waddr = i_q[AW-1:0];
				end
			end
			ST_UP_WR: begin
				we = 1'b1;
				waddr = src_q[AW-1:0];
				wdata = rdata;
			end
			ST_DN_RD: raddr = src_q[AW-1:0];
			ST_DN_WR: begin
				we = 1'b1;
				waddr = AW'(src_q - delta_q);
				wdata = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			held_q <= '0;
			mvalid_q <= 1'b0;
			phase_q <= PH_FIND_I;
			found_q <= 1'b0;
			status_q <= STATUS_OK;
		end else begin
			if (finish) begin
				mvalid_q <= 1'b1;
				done_q <= 1'b0;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						found_q <= 1'b0;
						status_q <= STATUS_OK;
						idx_q <= '0;
						if (s_tuser == KIND_POP) begin
							phase_q <= PH_POP;
							state_q <= ST_SCAN_RD;
						end else if (s_tdata[VB-1:0] > s_tdata[2*VB-1:VB]) begin
							status_q <= STATUS_ORDER;
							done_q <= 1'b1;
						end else begin
							phase_q <= PH_FIND_I;
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_SCAN_RD: begin
					if (idx_q == held_q) begin
						if (phase_q == PH_POP) begin
							src_q <= held_q;
							delta_q <= held_q;
							state_q <= ST_DN_RD;
						end else begin
							if (phase_q == PH_FIND_I) begin
								i_q <= idx_q;
							end
							state_q <= ST_RESOLVE;
						end
					end else begin
						state_q <= ST_SCAN_CHK;
					end
				end
				ST_SCAN_CHK: begin
					case (phase_q)
						PH_FIND_I: begin
							if (rd_hi < start_q) begin
								idx_q <= idx_q + CW'(1);
								state_q <= ST_SCAN_RD;
							end else if (rd_lo <= end_q) begin
								i_q <= idx_q;
								mlo_q <= (rd_lo < start_q) ? rd_lo : start_q;
								mhi_q <= (rd_hi > end_q) ? rd_hi : end_q;
								phase_q <= PH_FIND_J;
								idx_q <= idx_q + CW'(1);
								state_q <= ST_SCAN_RD;
							end else begin
								i_q <= idx_q;
								state_q <= ST_RESOLVE;
							end
						end
						PH_FIND_J: begin
							if (rd_lo <= end_q) begin
								mhi_q <= (rd_hi > end_q) ? rd_hi : end_q;
								idx_q <= idx_q + CW'(1);
								state_q <= ST_SCAN_RD;
							end else begin
								state_q <= ST_RESOLVE;
							end
						end
						default: begin
							if (rd_hi < value_q) begin
								idx_q <= idx_q + CW'(1);
								state_q <= ST_SCAN_RD;
							end else begin
								found_q <= (value_q >= rd_lo);
								if (value_q >= rd_lo && value_q == rd_hi) begin
									src_q <= idx_q + CW'(1);
									delta_q <= idx_q + CW'(1);
								end else begin
									src_q <= idx_q;
									delta_q <= idx_q;
								end
								state_q <= ST_DN_RD;
							end
						end
					endcase
				end
				ST_RESOLVE: begin
					if (phase_q == PH_FIND_J) begin
						src_q <= idx_q;
						delta_q <= idx_q - i_q - CW'(1);
						state_q <= ST_DN_RD;
					end else if (held_q == MAX_CNT) begin
						status_q <= STATUS_FULL;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						src_q <= held_q;
						state_q <= ST_UP_RD;
					end
				end
				ST_UP_RD: begin
					if (src_q == i_q) begin
						held_q <= held_q + CW'(1);
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_UP_WR;
					end
				end
				ST_UP_WR: begin
					src_q <= src_q - CW'(1);
					state_q <= ST_UP_RD;
				end
				ST_DN_RD: begin
					if (src_q == held_q) begin
						held_q <= held_q - delta_q;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DN_WR;
					end
				end
				ST_DN_WR: begin
					src_q <= src_q + CW'(1);
					state_q <= ST_DN_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_q <= s_tdata[VB-1:0];
			end_q <= s_tdata[2*VB-1:VB];
			value_q <= s_tdata[3*VB-1:2*VB];
		end
		if (finish) begin
			mdata_q <= OW'({held_q, held_q == '0, status_q, found_q});
		end
	end

`ifndef ASSERT_OFF
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= MAX_CNT)
		else $error("interval count exceeds table depth");
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CW'(waddr) <= held_q))
		else $error("write beyond the end of the held intervals");
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (mdata_q[3] == (mdata_q[4 +: CW] == '0)))
		else $error("empty flag disagrees with entry count");
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && status_q != STATUS_OK) |-> $stable(held_q))
		else $error("rejected add changed the table");
`endif
endmodule
